// ----- sv/lmcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcp_pkg
// Shared types, register indexes and fixed-point helpers for the logistic map
// column plotter.
// ----------------------------------------------------------------------------
package lmcp_pkg;

    // field widths
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int Q_W     = 32;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 7;
    localparam int SCR_W   = 11;
    localparam int IDX_W   = 8;
    localparam int FRAC_W  = 28;
    localparam int ROWSH_W = 44;
    localparam int OP_W    = 33;
    localparam int PROD_W  = 66;

    // one in Q4.28
    localparam logic signed [OP_W-1:0] ONE_Q = OP_W'(1) <<< FRAC_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SEED       = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_WARM_UP    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_PARAM_START = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PARAM_STEP = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_TOP_VALUE  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_ROWS_UNIT  = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_ITER_COUNT = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SCR_HEIGHT = IDX_W'(7);

    // configuration register file contents
    typedef struct packed {
        logic signed [Q_W-1:0] seed;
        logic                  warm_up_enable;
        logic signed [Q_W-1:0] param_start;
        logic [STEP_W-1:0]     param_step;
        logic signed [Q_W-1:0] top_value;
        logic [Q_W-1:0]        rows_per_unit;
        logic [ITER_W-1:0]     iteration_count;
        logic [SCR_W-1:0]      screen_height;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_col;
        logic mul_param;
        logic add_param;
        logic mul_ax;
        logic sat_ax;
        logic mul_omx;
        logic sat_x;
        logic row_mul;
        logic row_last;
    } cmd_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > PROD_W'(signed'(32'sh7fffffff))) begin
            r = 32'sh7fffffff;
        end else if (v < PROD_W'(signed'(32'sh80000000))) begin
            r = 32'sh80000000;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/lmcp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcp_cfg
// Configuration register file, written one word at a time by index.
// ----------------------------------------------------------------------------
module lmcp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lmcp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lmcp_pkg::Q_W-1:0]    cfg_data,
    output lmcp_pkg::cfg_t              cfg
);
    import lmcp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed            <= '0;
            cfg_reg.warm_up_enable  <= 1'b0;
            cfg_reg.param_start     <= '0;
            cfg_reg.param_step      <= STEP_W'(1048576);
            cfg_reg.top_value       <= Q_W'(268435456);
            cfg_reg.rows_per_unit   <= Q_W'(67108864);
            cfg_reg.iteration_count <= ITER_W'(64);
            cfg_reg.screen_height   <= SCR_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SEED:        cfg_reg.seed            <= cfg_data;
                REG_WARM_UP:     cfg_reg.warm_up_enable  <= cfg_data[0];
                REG_PARAM_START: cfg_reg.param_start     <= cfg_data;
                REG_PARAM_STEP:  cfg_reg.param_step      <= cfg_data[STEP_W-1:0];
                REG_TOP_VALUE:   cfg_reg.top_value       <= cfg_data;
                REG_ROWS_UNIT:   cfg_reg.rows_per_unit   <= cfg_data;
                REG_ITER_COUNT:  cfg_reg.iteration_count <= cfg_data[ITER_W-1:0];
                REG_SCR_HEIGHT:  cfg_reg.screen_height   <= cfg_data[SCR_W-1:0];
                default:         cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- sv/lmcp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcp_ctrl
// Sequencer: steps the shared multiplier through the parameter setup, the
// warm-up pass and the plotting pass of one column.
// ----------------------------------------------------------------------------
module lmcp_ctrl #(
    parameter int MAX_ITERATIONS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lmcp_pkg::cfg_t       cfg,
    output lmcp_pkg::cmd_t       cmd
);
    import lmcp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PARAM_MUL = 8'b0000_0010,
        ST_PARAM_ADD = 8'b0000_0100,
        ST_MUL_AX    = 8'b0000_1000,
        ST_SAT_AX    = 8'b0001_0000,
        ST_MUL_OMX   = 8'b0010_0000,
        ST_SAT_X     = 8'b0100_0000,
        ST_ROW_MUL   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                plot_phase_reg, plot_phase_next;
    logic [ITER_W-1:0]   count_eff;
    logic                iter_done;

    // pass length clamped to the iteration limit
    assign count_eff = (cfg.iteration_count > ITER_W'(MAX_ITERATIONS)) ?
                       ITER_W'(MAX_ITERATIONS) : cfg.iteration_count;
    assign iter_done = (iter_reg == count_eff);
    assign busy      = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        iter_next       = iter_reg;
        plot_phase_next = plot_phase_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_col = start;
                if (start && (count_eff != '0))
                begin
                    state_next = ST_PARAM_MUL;
                end
            end
            ST_PARAM_MUL:
            begin
                cmd.mul_param = 1'b1;
                state_next    = ST_PARAM_ADD;
            end
            ST_PARAM_ADD:
            begin
                cmd.add_param   = 1'b1;
                iter_next       = ITER_W'(1);
                plot_phase_next = !cfg.warm_up_enable;
                state_next      = ST_MUL_AX;
            end
            ST_MUL_AX:
            begin
                cmd.mul_ax = 1'b1;
                state_next = ST_SAT_AX;
            end
            ST_SAT_AX:
            begin
                cmd.sat_ax = 1'b1;
                state_next = ST_MUL_OMX;
            end
            ST_MUL_OMX:
            begin
                cmd.mul_omx = 1'b1;
                state_next  = ST_SAT_X;
            end
            ST_SAT_X:
            begin
                cmd.sat_x = 1'b1;
                if (plot_phase_reg)
                begin
                    state_next = ST_ROW_MUL;
                end
                else
                begin
                    state_next = ST_MUL_AX;
                    if (iter_done)
                    begin
                        plot_phase_next = 1'b1;
                        iter_next       = ITER_W'(1);
                    end
                    else
                    begin
                        iter_next = iter_reg + ITER_W'(1);
                    end
                end
            end
            ST_ROW_MUL:
            begin
                cmd.row_mul  = 1'b1;
                cmd.row_last = iter_done;
                if (iter_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    iter_next  = iter_reg + ITER_W'(1);
                    state_next = ST_MUL_AX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_reg       <= '0;
            plot_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iter_reg       <= iter_next;
            plot_phase_reg <= plot_phase_next;
        end
    end

endmodule

// ----- sv/lmcp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcp_dp
// Datapath: one shared signed multiplier, Q4.28 saturation, row conversion
// and the result register.
// ----------------------------------------------------------------------------
module lmcp_dp #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lmcp_pkg::cfg_t              cfg,
    input  lmcp_pkg::cmd_t              cmd,
    input  logic [lmcp_pkg::COL_W-1:0]  column,
    output logic                        valid,
    output logic [lmcp_pkg::COL_W-1:0]  out_column,
    output logic [lmcp_pkg::ROW_W-1:0]  row,
    output logic                        plot,
    output logic                        last
);
    import lmcp_pkg::*;

    localparam int RV_W = PROD_W - ROWSH_W;

    logic [COL_W-1:0]         col_reg;
    logic signed [Q_W-1:0]    a_reg;
    logic signed [Q_W-1:0]    x_reg;
    logic signed [Q_W-1:0]    t_reg;
    logic signed [Q_W-1:0]    omx_reg;
    logic signed [Q_W-1:0]    diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     row_phase_reg;
    logic                     row_last_reg;
    logic                     valid_reg;
    logic [COL_W-1:0]         out_column_reg;
    logic [ROW_W-1:0]         row_out_reg;
    logic                     plot_reg;
    logic                     last_reg;

    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [Q_W-1:0]    prod_q;
    logic signed [Q_W-1:0]    omx;
    logic signed [Q_W-1:0]    diff_new;
    logic signed [Q_W-1:0]    a_new;
    logic signed [PROD_W-1:0] rnd;
    logic signed [RV_W-1:0]   row_val;
    logic                     in_area;

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = OP_W'(signed'(a_reg));
        op_b = OP_W'(signed'(x_reg));
        if (cmd.mul_param)
        begin
            op_a = {2'b00, cfg.param_step};
            op_b = {{(OP_W-COL_W){1'b0}}, col_reg};
        end
        else if (cmd.mul_omx)
        begin
            op_a = OP_W'(signed'(t_reg));
            op_b = OP_W'(signed'(omx_reg));
        end
        else if (cmd.row_mul)
        begin
            op_a = OP_W'(signed'(diff_reg));
            op_b = {1'b0, cfg.rows_per_unit};
        end
    end

    // product rescaled to Q4.28 with floor shift and saturation
    assign prod_q   = sat32(prod_reg >>> FRAC_W);
    assign omx      = sat32(PROD_W'(ONE_Q - OP_W'(signed'(x_reg))));
    assign diff_new = sat32(PROD_W'(signed'(cfg.top_value)) - PROD_W'(signed'(prod_q)));
    assign a_new    = sat32(PROD_W'(signed'(cfg.param_start)) + prod_reg);

    // row truncated toward zero, then range check
    assign rnd     = prod_reg + (prod_reg[PROD_W-1] ?
                     PROD_W'((PROD_W'(1) <<< ROWSH_W) - PROD_W'(1)) : PROD_W'(0));
    assign row_val = RV_W'(rnd >>> ROWSH_W);
    assign in_area = !row_val[RV_W-1] &&
                     (row_val[RV_W-2:0] < (RV_W-1)'(cfg.screen_height)) &&
                     (32'(row_val[RV_W-2:0]) < 32'(MAX_ROWS)) &&
                     (32'(col_reg) < 32'(MAX_COLUMNS));

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_col)
        begin
            col_reg <= column;
        end
        if (cmd.mul_param || cmd.mul_ax || cmd.mul_omx || cmd.row_mul)
        begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.add_param)
        begin
            a_reg <= a_new;
            x_reg <= cfg.seed;
        end
        if (cmd.mul_ax)
        begin
            omx_reg <= omx;
        end
        if (cmd.sat_ax)
        begin
            t_reg <= prod_q;
        end
        if (cmd.sat_x)
        begin
            x_reg    <= prod_q;
            diff_reg <= diff_new;
        end
    end

    // result word, built the cycle after the row product
    always_ff @(posedge clk)
    begin
        if (row_phase_reg)
        begin
            out_column_reg <= col_reg;
            row_out_reg    <= in_area ? row_val[ROW_W-1:0] : '0;
            plot_reg       <= in_area;
            last_reg       <= row_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_phase_reg <= 1'b0;
            row_last_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            row_phase_reg <= cmd.row_mul;
            row_last_reg  <= cmd.row_last;
            valid_reg     <= row_phase_reg;
        end
    end

    assign valid      = valid_reg;
    assign out_column = out_column_reg;
    assign row        = row_out_reg;
    assign plot       = plot_reg;
    assign last       = last_reg;

endmodule

// ----- sv/logistic_map_column_plotter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_map_column_plotter
// Iterates the logistic map for one screen column and emits one plot point
// per iterate of the plotting pass.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction  handshake
//  command   start, busy, column                     in         start & !busy
//  result    valid, out_column, row, plot, last      out        valid strobe
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in       valid & ready
//
//  Busy covers one column: parameter setup, an optional warm-up pass and the
//  plotting pass of N iterates each, N the clamped iteration count; the shared
//  multiplier forms the parameter product, two products per warm-up iterate
//  and three per plotted iterate. A word trails its row product by the row
//  phase and result registers, the last after busy drops. A zero count returns
//  no words. Reset clears control and configuration; results never stall.
// ----------------------------------------------------------------------------
module logistic_map_column_plotter #(
    parameter int MAX_COLUMNS    = 1024,
    parameter int MAX_ROWS       = 1024,
    parameter int MAX_ITERATIONS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lmcp_pkg::COL_W-1:0]  column,
    output logic                        valid,
    output logic [lmcp_pkg::COL_W-1:0]  out_column,
    output logic [lmcp_pkg::ROW_W-1:0]  row,
    output logic                        plot,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lmcp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lmcp_pkg::Q_W-1:0]    cfg_data
);
    import lmcp_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    logic busy_int;
    logic start_acc;

    assign busy      = busy_int;
    assign start_acc = start && !busy_int;

    // configuration registers
    lmcp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    lmcp_ctrl #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_acc),
        .busy  (busy_int),
        .cfg   (cfg),
        .cmd   (cmd)
    );

    // arithmetic and result word
    lmcp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .column     (column),
        .valid      (valid),
        .out_column (out_column),
        .row        (row),
        .plot       (plot),
        .last       (last)
    );

endmodule
